FILE: hw/rtl/response_frame_receiver_defines.svh
// assertion macros shared by the response frame receiver rtl
`ifndef RESPONSE_FRAME_RECEIVER_DEFINES_SVH
`define RESPONSE_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rfr assertion failed");

// next-cycle implication, checked outside reset
`define RFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rfr assertion failed");

`endif

FILE: hw/rtl/rfr_pkg.sv
// types, codes and constants of the response frame receiver
`timescale 1ns / 1ps
package rfr_pkg;

	// command codes of an input item
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_FINISH  = 1'b1;

	// finish status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_LEN_ERR  = 3'd2;
	localparam logic [2:0] ST_HDR_SUM  = 3'd3;
	localparam logic [2:0] ST_DATA_SUM = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_FIRST_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_BYTE_TIMEOUT  = 2'd1;
	localparam logic [1:0] CFG_MAX_LENGTH    = 2'd2;

	localparam logic [7:0] FIRST_TIMEOUT_RST = 8'd50;
	localparam logic [7:0] BYTE_TIMEOUT_RST  = 8'd10;
	localparam logic [7:0] MAX_LENGTH_RST    = 8'd141;

	localparam int HEADER_LEN_DEF = 8;

	// body layout: fixed part, then payload, then checksum
	localparam logic [7:0] FIXED_PART    = 8'd11;
	localparam logic [3:0] CMD_HI_IDX    = 4'd4;
	localparam logic [3:0] CMD_LO_IDX    = 4'd5;
	localparam logic [3:0] ERR_FIRST_IDX = 4'd6;
	localparam logic [3:0] ERR_LAST_IDX  = 4'd9;
	localparam logic [3:0] PAYLOAD_IDX   = 4'd10;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_HDR_SUM,
		PH_BODY
	} phase_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [2:0]  status;
		logic [7:0]  command_high;
		logic [7:0]  command_low;
		logic [31:0] module_error;
		logic [7:0]  payload_count;
	} res_item_t;

	typedef struct packed {
		logic [7:0] first_timeout;
		logic [7:0] byte_timeout;
		logic [7:0] max_frame_length;
	} cfg_t;

	// sync header byte at a given position
	function automatic logic [7:0] sync_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0: b = 8'hF1;
			3'd1: b = 8'h1F;
			3'd2: b = 8'hE2;
			3'd3: b = 8'h2E;
			3'd4: b = 8'hB6;
			3'd5: b = 8'h6B;
			3'd6: b = 8'hA8;
			3'd7: b = 8'h8A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: hw/rtl/rfr_cfg_regs.sv
// configuration registers of the response frame receiver
`timescale 1ns / 1ps
module rfr_cfg_regs import rfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_timeout    <= FIRST_TIMEOUT_RST;
			cfg_q.byte_timeout     <= BYTE_TIMEOUT_RST;
			cfg_q.max_frame_length <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_TIMEOUT: cfg_q.first_timeout    <= cfg_wdata;
				CFG_BYTE_TIMEOUT:  cfg_q.byte_timeout     <= cfg_wdata;
				CFG_MAX_LENGTH:    cfg_q.max_frame_length <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/rfr_deframer.sv
// frame state and single-pass step logic of the response frame receiver
`timescale 1ns / 1ps
module rfr_deframer import rfr_pkg::*; #(
	parameter int HEADER_LEN = HEADER_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  rx_item_t  item,
	input  cfg_t      cfg,
	output logic      res_fire,
	output res_item_t res
);

	localparam int HPOS_W = $clog2(HEADER_LEN + 1);
	localparam logic [HPOS_W-1:0] HDR_LAST = HPOS_W'(HEADER_LEN - 1);

	phase_t            phase_q, phase_d;
	logic [HPOS_W-1:0] hpos_q, hpos_d;
	logic [7:0]        sum_q, sum_d;
	logic [7:0]        rem_q, rem_d;
	logic [3:0]        bidx_q, bidx_d;
	logic [7:0]        idle_q, idle_d;
	logic              seen_q, seen_d;
	logic [7:0]        cmd_hi_q, cmd_hi_d;
	logic [7:0]        cmd_lo_q, cmd_lo_d;
	logic [31:0]       err_q, err_d;
	logic [7:0]        flen_q, flen_d;

	logic [7:0] b;
	logic [7:0] sum_add;
	logic [7:0] idle_inc;
	logic [7:0] limit;
	logic [7:0] rem_dec;
	logic       timeout_hit;
	logic       len_bad;
	logic       hdr_match;

	assign b           = item.rx_byte;
	assign sum_add     = sum_q + b;
	assign idle_inc    = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
	assign limit       = seen_q ? cfg.byte_timeout : cfg.first_timeout;
	assign timeout_hit = idle_inc >= limit;
	assign rem_dec     = (rem_q != 8'd0) ? rem_q - 8'd1 : rem_q;
	assign len_bad     = (b < FIXED_PART) || (b > cfg.max_frame_length);
	assign hdr_match   = b == sync_byte(3'(hpos_q));

	// next state
	always_comb begin
		phase_d  = phase_q;
		hpos_d   = hpos_q;
		sum_d    = sum_q;
		rem_d    = rem_q;
		bidx_d   = bidx_q;
		idle_d   = idle_q;
		seen_d   = seen_q;
		cmd_hi_d = cmd_hi_q;
		cmd_lo_d = cmd_lo_q;
		err_d    = err_q;
		flen_d   = flen_q;
		if (item.cmd == CMD_START) begin
			phase_d  = PH_HUNT;
			hpos_d   = '0;
			sum_d    = '0;
			rem_d    = '0;
			bidx_d   = '0;
			idle_d   = '0;
			seen_d   = 1'b0;
			cmd_hi_d = '0;
			cmd_lo_d = '0;
			err_d    = '0;
			flen_d   = '0;
		end else if (item.cmd == CMD_NONE || phase_q == PH_IDLE) begin
			phase_d = phase_q;
		end else if (item.cmd == CMD_TICK) begin
			idle_d = idle_inc;
			if (timeout_hit)
				phase_d = PH_IDLE;
		end else begin
			idle_d = '0;
			seen_d = 1'b1;
			case (phase_q)
				PH_HUNT: begin
					if (hdr_match) begin
						sum_d  = sum_add;
						hpos_d = hpos_q + HPOS_W'(1);
						if (hpos_q == HDR_LAST)
							phase_d = PH_LEN_HI;
					end else begin
						sum_d  = '0;
						hpos_d = '0;
					end
				end
				PH_LEN_HI: begin
					sum_d   = sum_add;
					phase_d = (b != 8'd0) ? PH_IDLE : PH_LEN_LO;
				end
				PH_LEN_LO: begin
					sum_d = sum_add;
					if (len_bad) begin
						phase_d = PH_IDLE;
					end else begin
						flen_d  = b;
						phase_d = PH_HDR_SUM;
					end
				end
				PH_HDR_SUM: begin
					if (sum_add != 8'd0) begin
						sum_d   = sum_add;
						phase_d = PH_IDLE;
					end else begin
						sum_d   = '0;
						bidx_d  = '0;
						rem_d   = flen_q;
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					sum_d = sum_add;
					rem_d = rem_dec;
					if (bidx_q == CMD_HI_IDX)
						cmd_hi_d = b;
					else if (bidx_q == CMD_LO_IDX)
						cmd_lo_d = b;
					else if (bidx_q inside {[ERR_FIRST_IDX:ERR_LAST_IDX]})
						err_d = {err_q[23:0], b};
					if (bidx_q < PAYLOAD_IDX)
						bidx_d = bidx_q + 4'd1;
					if (rem_dec == 8'd0)
						phase_d = PH_IDLE;
				end
				default: ;
			endcase
		end
	end

	// result of this step
	always_comb begin
		res_fire = 1'b0;
		res      = '0;
		if (item.cmd == CMD_TICK && phase_q != PH_IDLE) begin
			if (timeout_hit) begin
				res_fire   = 1'b1;
				res.kind   = KIND_FINISH;
				res.status = ST_TIMEOUT;
			end
		end else if (item.cmd == CMD_BYTE) begin
			case (phase_q)
				PH_LEN_HI: begin
					if (b != 8'd0) begin
						res_fire   = 1'b1;
						res.kind   = KIND_FINISH;
						res.status = ST_LEN_ERR;
					end
				end
				PH_LEN_LO: begin
					if (len_bad) begin
						res_fire   = 1'b1;
						res.kind   = KIND_FINISH;
						res.status = ST_LEN_ERR;
					end
				end
				PH_HDR_SUM: begin
					if (sum_add != 8'd0) begin
						res_fire   = 1'b1;
						res.kind   = KIND_FINISH;
						res.status = ST_HDR_SUM;
					end
				end
				PH_BODY: begin
					if (rem_dec == 8'd0) begin
						res_fire          = 1'b1;
						res.kind          = KIND_FINISH;
						res.status        = (sum_add == 8'd0) ? ST_OK : ST_DATA_SUM;
						res.command_high  = cmd_hi_q;
						res.command_low   = cmd_lo_q;
						res.module_error  = err_q;
						res.payload_count = flen_q - FIXED_PART;
					end else if (bidx_q >= PAYLOAD_IDX) begin
						res_fire      = 1'b1;
						res.kind      = KIND_PAYLOAD;
						res.data_byte = b;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hpos_q   <= '0;
			sum_q    <= '0;
			rem_q    <= '0;
			bidx_q   <= '0;
			idle_q   <= '0;
			seen_q   <= 1'b0;
			cmd_hi_q <= '0;
			cmd_lo_q <= '0;
			err_q    <= '0;
			flen_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			hpos_q   <= hpos_d;
			sum_q    <= sum_d;
			rem_q    <= rem_d;
			bidx_q   <= bidx_d;
			idle_q   <= idle_d;
			seen_q   <= seen_d;
			cmd_hi_q <= cmd_hi_d;
			cmd_lo_q <= cmd_lo_d;
			err_q    <= err_d;
			flen_q   <= flen_d;
		end
	end

endmodule

FILE: hw/rtl/response_frame_receiver.sv
// top level of the response frame receiver
`timescale 1ns / 1ps
// response frame receiver: after a start command it hunts for the sync header,
// checks the length bytes and the header checksum, then takes the body and
// emits each payload byte as it arrives, closing a frame that ends or fails
// with one finish item that carries status and, for a frame that completes,
// command, module error and payload count; a new start drops a frame without
// one. idle ticks drive the first-byte and between-byte timeouts. one item is
// taken per clock: a transfer lands in the input register, the step logic
// works it in a single pass against the frame state, and any result goes to
// the result register, which drives the result channel. the result
// register alone sets the rate: while it holds an unclaimed result and
// the downstream side stalls, the input register keeps its item and rx_stall
// rises; otherwise rx_stall stays low. bytes and ticks outside an armed frame
// and the unused command code are absorbed without a result. configuration
// writes take effect on the next clock and are meant for an idle block.
`include "response_frame_receiver_defines.svh"
module response_frame_receiver import rfr_pkg::*; #(
	parameter int HEADER_LEN = HEADER_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// item channel
	input  logic       rx_valid,
	output logic       rx_stall,
	input  rx_item_t   rx_item,
	// result channel
	output logic       res_valid,
	input  logic       res_stall,
	output res_item_t  res_item,
	// configuration writes
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	cfg_t      cfg;
	rx_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	logic      step;
	logic      res_fire;
	res_item_t res_d;
	res_item_t res_q;
	logic      res_valid_q;

	// result register free or being drained this cycle
	assign advance  = !res_valid_q || !res_stall;
	assign step     = valid_s1 && advance;
	// hold the input register only when its item cannot move on
	assign rx_stall = valid_s1 && !advance;

	rfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rfr_deframer #(
		.HEADER_LEN (HEADER_LEN)
	) u_deframer (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.cfg      (cfg),
		.res_fire (res_fire),
		.res      (res_d)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall)
			item_s1 <= rx_item;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step && res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// stall upstream only behind a blocked, full result register
	`RFR_ASSERT_NOW(a_stall_cause, clk, arst_n, rx_stall,
		valid_s1 && res_valid_q && res_stall)
	// a payload byte never carries finish fields
	`RFR_ASSERT_NOW(a_payload_clean, clk, arst_n,
		res_valid_q && res_item.kind == KIND_PAYLOAD,
		res_item.status == ST_OK && res_item.payload_count == 8'd0)
	// a stepped item that makes a result shows it next cycle
	`RFR_ASSERT_NEXT(a_result_lands, clk, arst_n, step && res_fire, res_valid_q)

endmodule

FILE: bench/rfr_frame_checker.sv
// scoreboard of the response frame receiver: predicts each result and compares transfers
`timescale 1ns / 1ps
module rfr_frame_checker import rfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	input  logic       rx_stall,
	input  rx_item_t   rx_item,
	input  logic       res_valid,
	input  logic       res_stall,
	input  res_item_t  res_item,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output int         mismatches,
	output int         outstanding
);

	localparam int SYNC_LEN = HEADER_LEN_DEF;
	localparam logic [63:0] SYNC_WORD = 64'hF11F_E22E_B66B_A88A;

	// copy of the register file
	logic [7:0] lim_first, lim_byte, max_len;

	// copy of the frame state
	phase_t      ph;
	logic [3:0]  hdr_pos, body_pos;
	logic [7:0]  sum, remaining, idle_ticks, frame_len;
	logic        seen;
	logic [7:0]  cmd_hi, cmd_lo;
	logic [31:0] mod_err;

	res_item_t due_results[$];
	int err_count;

	function automatic void arm_hunt();
		ph = PH_HUNT;
		hdr_pos = '0;
		body_pos = '0;
		sum = '0;
		remaining = '0;
		idle_ticks = '0;
		frame_len = '0;
		seen = 1'b0;
		cmd_hi = '0;
		cmd_lo = '0;
		mod_err = '0;
	endfunction

	// closing item of a frame; early failures carry no frame details
	function automatic res_item_t frame_end(input logic [2:0] st, input bit report);
		res_item_t r;
		r = '0;
		r.kind = KIND_FINISH;
		r.status = st;
		if (report) begin
			r.command_high = cmd_hi;
			r.command_low = cmd_lo;
			r.module_error = mod_err;
			r.payload_count = frame_len - FIXED_PART;
		end
		ph = PH_IDLE;
		return r;
	endfunction

	// one accepted item against the frame state; returns 1 when it yields a result
	function automatic bit deframe_step(input rx_item_t it, output res_item_t r);
		logic [7:0] b;
		logic [7:0] lim;
		logic [3:0] pos;
		b = it.rx_byte;
		r = '0;
		if (it.cmd == CMD_START) begin
			arm_hunt();
			return 1'b0;
		end
		if (it.cmd == CMD_NONE || ph == PH_IDLE)
			return 1'b0;
		if (it.cmd == CMD_TICK) begin
			lim = seen ? lim_byte : lim_first;
			if (idle_ticks != 8'hFF)
				idle_ticks++;
			if (idle_ticks >= lim) begin
				r = frame_end(ST_TIMEOUT, 1'b0);
				return 1'b1;
			end
			return 1'b0;
		end
		idle_ticks = '0;
		seen = 1'b1;
		sum = sum + b;
		case (ph)
			PH_HUNT: begin
				if (hdr_pos < SYNC_LEN && b == SYNC_WORD[8 * (7 - hdr_pos[2:0]) +: 8]) begin
					hdr_pos++;
					if (hdr_pos >= SYNC_LEN)
						ph = PH_LEN_HI;
				end else begin
					sum = '0;
					hdr_pos = '0;
				end
			end
			PH_LEN_HI: begin
				if (b != 8'd0) begin
					r = frame_end(ST_LEN_ERR, 1'b0);
					return 1'b1;
				end
				ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (b < FIXED_PART || b > max_len) begin
					r = frame_end(ST_LEN_ERR, 1'b0);
					return 1'b1;
				end
				frame_len = b;
				ph = PH_HDR_SUM;
			end
			PH_HDR_SUM: begin
				if (sum != 8'd0) begin
					r = frame_end(ST_HDR_SUM, 1'b0);
					return 1'b1;
				end
				ph = PH_BODY;
				sum = '0;
				body_pos = '0;
				remaining = frame_len;
			end
			PH_BODY: begin
				pos = body_pos;
				if (remaining != 8'd0)
					remaining--;
				if (pos == CMD_HI_IDX)
					cmd_hi = b;
				else if (pos == CMD_LO_IDX)
					cmd_lo = b;
				else if (pos >= ERR_FIRST_IDX && pos <= ERR_LAST_IDX)
					mod_err = {mod_err[23:0], b};
				if (pos < PAYLOAD_IDX)
					body_pos++;
				if (remaining == 8'd0) begin
					r = frame_end((sum == 8'd0) ? ST_OK : ST_DATA_SUM, 1'b1);
					return 1'b1;
				end
				if (pos >= PAYLOAD_IDX) begin
					r.kind = KIND_PAYLOAD;
					r.data_byte = b;
					return 1'b1;
				end
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		res_item_t guess;
		if (!arst_n) begin
			lim_first = FIRST_TIMEOUT_RST;
			lim_byte = BYTE_TIMEOUT_RST;
			max_len = MAX_LENGTH_RST;
			arm_hunt();
			ph = PH_IDLE;
			due_results.delete();
			err_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_TIMEOUT: lim_first = cfg_wdata;
					CFG_BYTE_TIMEOUT:  lim_byte = cfg_wdata;
					CFG_MAX_LENGTH:    max_len = cfg_wdata;
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					$error("result transfer with nothing expected: 0x%0h", res_item);
					err_count++;
				end else begin
					want = due_results.pop_front();
					check_field("kind", want.kind, res_item.kind);
					check_field("data_byte", want.data_byte, res_item.data_byte);
					check_field("status", want.status, res_item.status);
					check_field("command_high", want.command_high, res_item.command_high);
					check_field("command_low", want.command_low, res_item.command_low);
					check_field("module_error", want.module_error, res_item.module_error);
					check_field("payload_count", want.payload_count, res_item.payload_count);
				end
			end
			if (rx_valid && !rx_stall) begin
				if (deframe_step(rx_item, guess))
					due_results.push_back(guess);
			end
			mismatches <= err_count;
			outstanding <= due_results.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// top of the response frame receiver bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
	import rfr_pkg::*;

	localparam int ITEM_GOAL = 1350;
	localparam int PHASES = 8;
	// long receiver hold-off, enough for the block to back up into rx_stall
	localparam int HOLD_CYCLES = 300;
	// a result passes the input and result registers after its transfer; margin on top
	localparam int DRAIN_CYCLES = 4;
	// byte positions inside a built frame
	localparam int LEN_HI_POS = HEADER_LEN_DEF;
	localparam int LEN_LO_POS = HEADER_LEN_DEF + 1;
	localparam int HDR_SUM_POS = HEADER_LEN_DEF + 2;

	// ways a generated frame can go wrong
	typedef enum int {
		FR_GOOD,
		FR_BAD_SYNC,
		FR_BAD_LEN_HI,
		FR_BAD_LEN_LO,
		FR_BAD_HDR_SUM,
		FR_BAD_DATA_SUM,
		FR_TIMEOUT,
		FR_RESTART,
		FR_CUT
	} frame_fault_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	rx_item_t   rx_item = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_item_t  res_item;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;

	int mismatches;
	int outstanding;

	// stimulus-side view of the registers, used only to shape frames
	logic [7:0] cur_first = FIRST_TIMEOUT_RST;
	logic [7:0] cur_byte = BYTE_TIMEOUT_RST;
	logic [7:0] cur_max = MAX_LENGTH_RST;

	int items_sent = 0;
	int hold_req = 0;
	bit tx_calm = 1'b0;
	bit res_calm = 1'b0;

	response_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_item(rx_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	rfr_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_item(rx_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: random stall runs, mostly short; a hold request from the
	// stimulus process gets one long stall counted here
	initial begin
		int run;
		int r;
		int hold_seen;
		run = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
				run = 0;
			end else if (run > 0) begin
				run--;
			end else begin
				r = $urandom_range(0, 99);
				if (res_calm || r < 60) begin
					res_stall <= 1'b0;
					run = $urandom_range(0, 20);
				end else if (r < 92) begin
					res_stall <= 1'b1;
					run = $urandom_range(0, 2);
				end else begin
					res_stall <= 1'b1;
					run = $urandom_range(8, 40);
				end
			end
		end
	end

	// one item transfer, with an optional gap in front; valid stays high
	// straight into the next item when there is no gap
	task automatic offer(input logic [1:0] op, input logic [7:0] value);
		int gap;
		int r;
		gap = 0;
		if (!tx_calm) begin
			r = $urandom_range(0, 99);
			if (r >= 97)
				gap = $urandom_range(8, 40);
			else if (r >= 80)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_item <= '{cmd: op, rx_byte: value};
		do @(posedge clk); while (rx_stall);
		items_sent++;
	endtask

	task automatic tick_run(input int n);
		repeat (n) offer(CMD_TICK, 8'($urandom));
	endtask

	// stop offering, let every expected result out, then give items that
	// make no result time to pass through before touching registers
	task automatic settle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// back-to-back writes of all three registers, enable held high throughout
	task automatic write_limits(input logic [7:0] first, input logic [7:0] between,
			input logic [7:0] longest);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIRST_TIMEOUT;
		cfg_wdata <= first;
		@(posedge clk);
		cfg_index <= CFG_BYTE_TIMEOUT;
		cfg_wdata <= between;
		@(posedge clk);
		cfg_index <= CFG_MAX_LENGTH;
		cfg_wdata <= longest;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_first = first;
		cur_byte = between;
		cur_max = longest;
	endtask

	// one response frame: start, optional leading ticks and junk, then the
	// sync header, length, header checksum and body with ticks mixed in;
	// most frames are clean, the rest carry one fault; jumbo is a clean
	// frame of maximum length sent without gaps
	task automatic send_frame(input bit jumbo);
		logic [7:0] fb[$];
		logic [7:0] acc;
		logic [7:0] b;
		frame_fault_t fault;
		int len;
		int r;
		int n;
		int i;
		int stop;
		fb = {};
		r = $urandom_range(0, 99);
		if (jumbo || r < 62)
			fault = FR_GOOD;
		else if (r < 66)
			fault = FR_BAD_SYNC;
		else if (r < 70)
			fault = FR_BAD_LEN_HI;
		else if (r < 74)
			fault = FR_BAD_LEN_LO;
		else if (r < 78)
			fault = FR_BAD_HDR_SUM;
		else if (r < 83)
			fault = FR_BAD_DATA_SUM;
		else if (r < 91)
			fault = FR_TIMEOUT;
		else if (r < 95)
			fault = FR_RESTART;
		else
			fault = FR_CUT;

		// mostly short bodies, now and then the largest one allowed
		r = $urandom_range(0, 19);
		if (jumbo)
			len = cur_max;
		else if (cur_max < FIXED_PART)
			len = $urandom_range(0, 255);
		else if (r == 0)
			len = cur_max;
		else if (r == 1)
			len = FIXED_PART;
		else if (r < 4)
			len = $urandom_range(FIXED_PART, cur_max);
		else
			len = $urandom_range(FIXED_PART, (cur_max > 40) ? 40 : cur_max);

		// header part: sync bytes, length, then a checksum that zeroes the sum
		acc = 8'd0;
		for (i = 0; i < HEADER_LEN_DEF; i++) begin
			fb.push_back(sync_byte(i[2:0]));
			acc += fb[i];
		end
		fb.push_back(8'd0);
		fb.push_back(len[7:0]);
		fb.push_back(8'd0 - acc - len[7:0]);
		// body: random content, last byte zeroes the body sum
		acc = 8'd0;
		for (i = 1; i < len; i++) begin
			b = 8'($urandom);
			fb.push_back(b);
			acc += b;
		end
		if (len > 0)
			fb.push_back(8'd0 - acc);

		stop = fb.size();
		case (fault)
			FR_BAD_SYNC: begin
				i = $urandom_range(0, HEADER_LEN_DEF - 1);
				fb[i] = fb[i] ^ 8'($urandom_range(1, 255));
			end
			FR_BAD_LEN_HI: fb[LEN_HI_POS] = 8'($urandom_range(1, 255));
			FR_BAD_LEN_LO: begin
				if (cur_max < 8'hFF && $urandom_range(0, 1) == 1)
					fb[LEN_LO_POS] = 8'($urandom_range(cur_max + 1, 255));
				else
					fb[LEN_LO_POS] = 8'($urandom_range(0, FIXED_PART - 1));
			end
			FR_BAD_HDR_SUM: fb[HDR_SUM_POS] = fb[HDR_SUM_POS] ^ 8'($urandom_range(1, 255));
			FR_BAD_DATA_SUM: fb[fb.size() - 1] = fb[fb.size() - 1] ^ 8'($urandom_range(1, 255));
			FR_TIMEOUT, FR_RESTART, FR_CUT: stop = $urandom_range(1, fb.size() - 1);
			default: ;
		endcase

		offer(CMD_START, 8'($urandom));
		// ticks before any byte count against the first-byte limit
		if (!jumbo && cur_first > 1 && $urandom_range(0, 3) == 0)
			tick_run($urandom_range(1, (cur_first > 6) ? 5 : cur_first - 1));
		// junk ahead of the header; the first sync value would swallow the real one
		if (!jumbo && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				b = 8'($urandom);
				if (b == sync_byte(3'd0))
					b = 8'h00;
				offer(CMD_BYTE, b);
			end
		end
		for (i = 0; i < stop; i++) begin
			offer(CMD_BYTE, fb[i]);
			if (!jumbo && cur_byte > 1 && $urandom_range(0, 9) == 0)
				tick_run($urandom_range(1, (cur_byte > 4) ? 4 : cur_byte - 1));
		end
		case (fault)
			FR_TIMEOUT: tick_run((cur_byte == 8'd0) ? 1 : cur_byte);
			FR_RESTART: offer(CMD_START, 8'($urandom));
			default: ;
		endcase
		// occasional loose items of any kind between frames
		if (!jumbo && $urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) offer(2'($urandom_range(0, 3)), 8'($urandom));
		end
	endtask

	initial begin
		int phase_no;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening under reset register values
		offer(CMD_BYTE, 8'h00);   // byte while idle, dropped
		offer(CMD_TICK, 8'hFF);   // tick while idle, dropped
		offer(CMD_NONE, 8'hFF);   // unused code
		offer(CMD_START, 8'h00);
		offer(CMD_NONE, 8'h5A);   // unused code while armed, no effect
		offer(CMD_BYTE, sync_byte(3'd0));
		offer(CMD_BYTE, sync_byte(3'd1));
		offer(CMD_BYTE, 8'h00);   // sync mismatch, hunt starts over
		offer(CMD_START, 8'hFF);  // restart while hunting
		for (int i = 0; i < HEADER_LEN_DEF; i++)
			offer(CMD_BYTE, sync_byte(i[2:0]));
		offer(CMD_BYTE, 8'h80);   // nonzero length high byte
		offer(CMD_TICK, 8'h00);   // idle again

		for (phase_no = 0; phase_no < PHASES; phase_no++) begin
			settle();
			case (phase_no)
				0: ;
				1: write_limits(8'd1, 8'd1, FIXED_PART);
				2: write_limits(8'hFF, 8'hFF, 8'hFF);
				// zero limits time out on the first tick, a short maximum rejects all
				3: write_limits(8'd0, 8'd0, 8'd5);
				default: write_limits(8'($urandom_range(2, 80)), 8'($urandom_range(2, 40)),
						8'($urandom_range(FIXED_PART, 255)));
			endcase
			res_calm <= ($urandom_range(0, 3) == 0);
			if (phase_no == 2) begin
				// receiver holds off while a long frame streams in
				hold_req <= hold_req + 1;
				tx_calm = 1'b1;
				send_frame(1'b1);
			end
			while (items_sent < (phase_no + 1) * ITEM_GOAL / PHASES) begin
				tx_calm = ($urandom_range(0, 4) == 0);
				send_frame(1'b0);
			end
		end

		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rfr_pkg.sv
hw/rtl/rfr_cfg_regs.sv
hw/rtl/rfr_deframer.sv
hw/rtl/response_frame_receiver.sv
bench/rfr_frame_checker.sv
bench/testbench.sv
